FILE: src/bmhq_pkg.sv
// Shared types and constants for the bounded min-heap queue.
`timescale 1ns / 1ps
package bmhq_pkg;

    localparam int PRIO_W = 32;
    localparam int DATA_W = 32;
    localparam int FILL_W = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [PRIO_W-1:0] priority_req;
        logic [DATA_W-1:0]        payload;
    } t_req;

    typedef struct packed {
        logic                     ok;
        logic signed [PRIO_W-1:0] out_priority;
        logic [DATA_W-1:0]        out_payload;
        logic [FILL_W-1:0]        fill_count;
    } t_rsp;

endpackage

FILE: src/bmhq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
module bmhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: src/bmhq_cmp.sv
// Shared signed priority comparator used by both sift directions.
`timescale 1ns / 1ps
module bmhq_cmp
    import bmhq_pkg::*;
(
    input  logic signed [PRIO_W-1:0] i_a,
    input  logic signed [PRIO_W-1:0] i_b,
    output logic                     o_less
);

    assign o_less = (i_a < i_b);

endmodule

FILE: src/bounded_min_heap_queue_unit.sv
// Top level: bounded min-heap priority queue with sift sequencer.
// A push places the new entry in the next free slot (the last slot when the heap is full)
// and climbs toward the root; a pop of an empty heap answers with ok low.
// Other pops sink the hole left at the root; unless it ends on the last slot, the last
// entry is then fetched and climbs from the hole.
// One request at a time, busy until the result cycle; sync active-low reset empties the heap.
`timescale 1ns / 1ps
module bounded_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int EW = PRIO_W + PAYLOAD_BITS;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_C = AW'(CAPACITY - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_POP_TOP  = 7'b0000010,
        S_SINK_RD  = 7'b0000100,
        S_SINK_CMP = 7'b0001000,
        S_LAST_CAP = 7'b0010000,
        S_RISE_RD  = 7'b0100000,
        S_RISE_CMP = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_pos,   n_pos;
    logic [EW-1:0]   r_ent,   n_ent;
    logic            r_strobe, n_strobe;
    t_rsp            r_rsp,   n_rsp;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [EW-1:0]   ram_wdata, rd_a, rd_b;

    logic signed [PRIO_W-1:0] cmp_a, cmp_b;
    logic                     cmp_less;

    logic [AW-1:0] parent;
    logic [XW-1:0] left_x, right_x, count_x;
    logic [CW+FILL_W-1:0] fill_x;

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (rd_b)
    );

    bmhq_cmp u_cmp (
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_less (cmp_less)
    );

    assign parent  = (r_pos - AW'(1)) >> 1;
    assign left_x  = XW'({r_pos, 1'b1});
    assign right_x = XW'({r_pos, 1'b0}) + XW'(2);
    assign count_x = XW'(r_count);
    assign fill_x  = {{FILL_W{1'b0}}, r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ent       = r_ent;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_ent;
        ram_raddr_a = parent;
        ram_raddr_b = right_x[AW-1:0];
        cmp_a       = $signed(r_ent[EW-1 -: PRIO_W]);
        cmp_b       = $signed(rd_a[EW-1 -: PRIO_W]);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.operation == OP_PUSH) begin
                        n_ent = {i_req.priority_req, i_req.payload[PAYLOAD_BITS-1:0]};
                        if (r_count == CAP_C) begin
                            n_pos = LAST_C;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                        n_rsp.ok           = 1'b1;
                        n_rsp.out_priority = '0;
                        n_rsp.out_payload  = '0;
                        n_state            = S_RISE_RD;
                    end else if (r_count == '0) begin
                        n_rsp.ok           = 1'b0;
                        n_rsp.out_priority = '0;
                        n_rsp.out_payload  = '0;
                        n_rsp.fill_count   = fill_x[FILL_W-1:0];
                        n_strobe           = 1'b1;
                    end else begin
                        ram_raddr_a = '0;
                        n_count     = r_count - CW'(1);
                        n_pos       = '0;
                        n_state     = S_POP_TOP;
                    end
                end
            end
            S_POP_TOP: begin
                n_rsp.ok           = 1'b1;
                n_rsp.out_priority = $signed(rd_a[EW-1 -: PRIO_W]);
                n_rsp.out_payload  = DATA_W'(rd_a[PAYLOAD_BITS-1:0]);
                if (r_count == '0) begin
                    n_rsp.fill_count = fill_x[FILL_W-1:0];
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_SINK_RD;
                end
            end
            S_SINK_RD: begin
                if (right_x > count_x) begin
                    if (r_pos == r_count[AW-1:0]) begin
                        n_rsp.fill_count = fill_x[FILL_W-1:0];
                        n_strobe         = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        ram_raddr_a = r_count[AW-1:0];
                        n_state     = S_LAST_CAP;
                    end
                end else begin
                    ram_raddr_a = left_x[AW-1:0];
                    ram_raddr_b = right_x[AW-1:0];
                    n_state     = S_SINK_CMP;
                end
            end
            S_SINK_CMP: begin
                // right child wins ties
                cmp_a  = $signed(rd_a[EW-1 -: PRIO_W]);
                cmp_b  = $signed(rd_b[EW-1 -: PRIO_W]);
                ram_we = 1'b1;
                if (cmp_less) begin
                    ram_wdata = rd_a;
                    n_pos     = left_x[AW-1:0];
                end else begin
                    ram_wdata = rd_b;
                    n_pos     = right_x[AW-1:0];
                end
                n_state = S_SINK_RD;
            end
            S_LAST_CAP: begin
                n_ent   = rd_a;
                n_state = S_RISE_RD;
            end
            S_RISE_RD: begin
                if (r_pos == '0) begin
                    ram_we           = 1'b1;
                    n_rsp.fill_count = fill_x[FILL_W-1:0];
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_RISE_CMP;
                end
            end
            S_RISE_CMP: begin
                ram_we = 1'b1;
                if (cmp_less) begin
                    ram_wdata = rd_a;
                    n_pos     = parent;
                    n_state   = S_RISE_RD;
                end else begin
                    n_rsp.fill_count = fill_x[FILL_W-1:0];
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_pos <= n_pos;
        r_ent <= n_ent;
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

FILE: tb/bounded_min_heap_queue_unit_tb.sv
// Testbench for the bounded min-heap queue: random push/pop traffic checked against a shadow heap.
`timescale 1ns / 1ps
module bounded_min_heap_queue_unit_tb;
    import bmhq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam logic [DATA_W-1:0] PAYLOAD_MASK = DATA_W'((64'd1 << PAYLOAD_BITS) - 1);
    localparam int RANDOM_REQS  = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    class heap_shadow;
        logic signed [PRIO_W-1:0] slot_prio [DEPTH];
        logic [DATA_W-1:0]        slot_data [DEPTH];
        int unsigned              live;
        t_rsp                     expected_q [$];
        int unsigned              mismatches;

        function new();
            live = 0;
            mismatches = 0;
            foreach (slot_prio[i]) begin
                slot_prio[i] = '0;
                slot_data[i] = '0;
            end
        endfunction

        task flag(string msg);
            if (mismatches < 100)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void sift_up(int unsigned pos, logic signed [PRIO_W-1:0] p,
                              logic [DATA_W-1:0] d);
            int unsigned parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(p < slot_prio[parent]))
                    break;
                slot_prio[pos] = slot_prio[parent];
                slot_data[pos] = slot_data[parent];
                pos = parent;
            end
            slot_prio[pos] = p;
            slot_data[pos] = d;
        endfunction

        function void note_request(t_req r);
            t_rsp        rsp;
            int unsigned pos;
            int unsigned hole;
            int unsigned kid_l;
            int unsigned kid_r;
            int unsigned n;
            rsp = '0;
            rsp.ok = 1'b1;
            if (r.operation == OP_PUSH) begin
                pos = live;
                // full: last slot is overwritten
                if (pos >= DEPTH) begin
                    live = DEPTH - 1;
                    pos = DEPTH - 1;
                end
                sift_up(pos, r.priority_req, r.payload & PAYLOAD_MASK);
                live++;
            end else if (live == 0) begin
                rsp.ok = 1'b0;
            end else begin
                n = live;
                rsp.out_priority = slot_prio[0];
                rsp.out_payload  = slot_data[0];
                if (n > 1) begin
                    hole = 0;
                    forever begin
                        kid_l = 2 * hole + 1;
                        kid_r = 2 * hole + 2;
                        if (kid_r >= n)
                            break;
                        // tie goes to the right child
                        if (slot_prio[kid_l] < slot_prio[kid_r]) begin
                            slot_prio[hole] = slot_prio[kid_l];
                            slot_data[hole] = slot_data[kid_l];
                            hole = kid_l;
                        end else begin
                            slot_prio[hole] = slot_prio[kid_r];
                            slot_data[hole] = slot_data[kid_r];
                            hole = kid_r;
                        end
                    end
                    if (hole != n - 1)
                        sift_up(hole, slot_prio[n - 1], slot_data[n - 1]);
                end
                live = n - 1;
            end
            rsp.fill_count = FILL_W'(live);
            expected_q.push_back(rsp);
        endfunction

        task check_response(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                flag("result strobe with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok)
                flag($sformatf("ok got %b want %b", got.ok, want.ok));
            if (got.out_priority !== want.out_priority)
                flag($sformatf("out_priority got %0d want %0d",
                               got.out_priority, want.out_priority));
            if (got.out_payload !== want.out_payload)
                flag($sformatf("out_payload got %h want %h",
                               got.out_payload, want.out_payload));
            if (got.fill_count !== want.fill_count)
                flag($sformatf("fill_count got %0d want %0d",
                               got.fill_count, want.fill_count));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_req        i_req;
    logic        busy;
    logic        o_strobe;
    t_rsp        o_rsp;
    heap_shadow  shadow;
    int unsigned cycle_cnt;

    bounded_min_heap_queue_unit #(
        .CAPACITY     (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                shadow.check_response(o_rsp);
            if (start && !busy)
                shadow.note_request(i_req);
        end
    end

    // called at a rising edge; returns at the edge that accepts the request
    task automatic drive_req(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic push_req(input logic signed [PRIO_W-1:0] p, input logic [DATA_W-1:0] d);
        t_req r;
        r.operation    = OP_PUSH;
        r.priority_req = p;
        r.payload      = d;
        drive_req(r);
    endtask

    task automatic pop_req();
        t_req r;
        r.operation    = OP_POP;
        r.priority_req = $urandom;
        r.payload      = $urandom;
        drive_req(r);
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [PRIO_W-1:0] rand_prio();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return PRIO_W'(int'($urandom_range(0, 7)) - 4);
        else if (pick < 9)
            return $urandom;
        else
            return pick[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    initial begin
        int unsigned sent;
        int unsigned push_pct;
        int unsigned burst;
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_req     = '0;
        cycle_cnt = 0;
        shadow    = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, extremes, ties, overflow of a full heap, pops
        pop_req();
        push_req(32'sh7FFF_FFFF, 32'h0000_0000);
        push_req(32'sh8000_0000, 32'hFFFF_FFFF);
        push_req(32'sh0000_0000, 32'hAAAA_AAAA);
        push_req(-32'sd1, 32'h5555_5555);
        for (int i = 1; i <= 4; i++)
            push_req(32'sd5, DATA_W'(i));
        for (int i = 0; i < 9; i++)
            push_req(PRIO_W'(int'($urandom_range(0, 6)) - 3), $urandom);
        for (int i = 0; i < 5; i++)
            pop_req();

        sent = 0;
        push_pct = 50;
        while (sent < RANDOM_REQS) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++) begin
                if (sent % 60 == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_pct = 20;
                        1: push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                if ($urandom_range(1, 100) <= push_pct)
                    push_req(rand_prio(), $urandom);
                else
                    pop_req();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 7));
        end
        idle_cycles(1);

        while (shadow.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
